FILE: src/lfn_pkg.sv
`default_nettype none
package lfn_pkg;

    localparam int MAX_STAGES_DEF = 8;
    localparam int SAMPLE_W       = 24;
    localparam int ACC_W          = 32;
    localparam int COEF_W         = 16;
    localparam int PROD_W         = ACC_W + COEF_W;
    localparam int CNT_W          = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int ROUND_SHIFT    = 15;

    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFFS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFFS_HIGH = 2'd2;

    // microprogram addresses
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
    localparam logic [PC_W-1:0] PC_MULF = 3'd1;
    localparam logic [PC_W-1:0] PC_MULD = 3'd2;
    localparam logic [PC_W-1:0] PC_UPD  = 3'd3;
    localparam logic [PC_W-1:0] PC_EMIT = 3'd4;

    typedef enum logic [1:0] {
        COND_NEXT,   // fall through
        COND_IN,     // wait for a sample; jump if no stages in use
        COND_MORE,   // jump back while stages remain
        COND_OUT     // wait for the output register, then jump
    } t_cond;

    typedef struct packed {
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            mul_f;
        logic            mul_d;
        logic            g_sub;
        logic            f_add;
    } t_uword;

    typedef struct packed {
        logic load;
        logic mul_f;
        logic mul_d;
        logic g_sub;
        logic f_add;
        logic emit;
    } t_ctrl;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{cond: COND_OUT, target: PC_IDLE, mul_f: 1'b0, mul_d: 1'b0,
              g_sub: 1'b0, f_add: 1'b0};
        unique case (pc)
            PC_IDLE: begin
                w.cond   = COND_IN;
                w.target = PC_EMIT;
            end
            PC_MULF: begin
                w.cond  = COND_NEXT;
                w.mul_f = 1'b1;
            end
            PC_MULD: begin
                w.cond  = COND_NEXT;
                w.mul_d = 1'b1;
                w.g_sub = 1'b1;
            end
            PC_UPD: begin
                w.cond   = COND_MORE;
                w.target = PC_MULF;
                w.f_add  = 1'b1;
            end
            PC_EMIT: begin
                w.cond   = COND_OUT;
                w.target = PC_IDLE;
            end
            default: begin
                w.cond   = COND_OUT;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W-1:0] res;
        if (v > $signed({3'b000, {(ACC_W-1){1'b1}}})) begin
            res = {1'b0, {(ACC_W-1){1'b1}}};
        end else if (v < $signed({3'b111, {(ACC_W-1){1'b0}}})) begin
            res = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

    // round half up, drop 15 fraction bits, saturate to the accumulator
    function automatic logic signed [ACC_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] r;
        r = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(1 << (ROUND_SHIFT - 1)));
        return sat_acc(r[PROD_W:ROUND_SHIFT]);
    endfunction

    function automatic logic signed [ACC_W-1:0] add_sat(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b,
                                                       input logic                    sub);
        logic signed [ACC_W+1:0] s;
        if (sub) begin
            s = $signed({{2{a[ACC_W-1]}}, a}) - $signed({{2{b[ACC_W-1]}}, b});
        end else begin
            s = $signed({{2{a[ACC_W-1]}}, a}) + $signed({{2{b[ACC_W-1]}}, b});
        end
        return sat_acc(s);
    endfunction

endpackage
`default_nettype wire

FILE: src/lfn_sequencer.sv
`default_nettype none
module lfn_sequencer
    import lfn_pkg::*;
#(
    parameter int MAX_STAGES = MAX_STAGES_DEF,
    parameter int STG_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_free,
    input  wire logic [CNT_W-1:0] i_n_stages,
    output logic                  o_in_ready,
    output t_ctrl                 o_ctrl,
    output logic [STG_W-1:0]      o_stage
);

    logic [PC_W-1:0]  r_pc;
    logic [PC_W-1:0]  n_pc;
    logic [STG_W-1:0] r_stage;
    logic [STG_W-1:0] n_stage;
    t_uword           uw;
    logic [CNT_W-1:0] stage_inc;
    logic             more;

    assign uw        = ucode(r_pc);
    assign stage_inc = CNT_W'(r_stage) + CNT_W'(1);
    assign more      = stage_inc < i_n_stages;

    // next step
    always_comb begin
        n_pc    = r_pc;
        n_stage = r_stage;
        unique case (uw.cond)
            COND_NEXT: n_pc = r_pc + PC_W'(1);
            COND_IN: begin
                if (i_in_valid) begin
                    n_stage = '0;
                    n_pc    = (i_n_stages == '0) ? uw.target : r_pc + PC_W'(1);
                end
            end
            COND_MORE: begin
                if (more) begin
                    n_pc    = uw.target;
                    n_stage = r_stage + STG_W'(1);
                end else begin
                    n_pc = r_pc + PC_W'(1);
                end
            end
            COND_OUT: begin
                if (i_out_free) begin
                    n_pc = uw.target;
                end
            end
            default: n_pc = PC_IDLE;
        endcase
    end

    // control word decode
    always_comb begin
        o_in_ready   = (uw.cond == COND_IN);
        o_ctrl.load  = (uw.cond == COND_IN) && i_in_valid;
        o_ctrl.emit  = (uw.cond == COND_OUT) && i_out_free;
        o_ctrl.mul_f = uw.mul_f;
        o_ctrl.mul_d = uw.mul_d;
        o_ctrl.g_sub = uw.g_sub;
        o_ctrl.f_add = uw.f_add;
        o_stage      = r_stage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_IDLE;
            r_stage <= '0;
        end else begin
            r_pc    <= n_pc;
            r_stage <= n_stage;
        end
    end

endmodule
`default_nettype wire

FILE: src/lfn_datapath.sv
`default_nettype none
module lfn_datapath
    import lfn_pkg::*;
#(
    parameter int MAX_STAGES = MAX_STAGES_DEF,
    parameter int STG_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire t_ctrl                      i_ctrl,
    input  wire logic [STG_W-1:0]           i_stage,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic [CFG_DATA_W-1:0]      i_coeffs_low,
    input  wire logic [CFG_DATA_W-1:0]      i_coeffs_high,
    output logic signed [SAMPLE_W-1:0]      o_result
);

    logic signed [ACC_W-1:0]  r_f;
    logic signed [ACC_W-1:0]  r_g;
    logic signed [ACC_W-1:0]  r_gn;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_delay [MAX_STAGES];

    logic [2*CFG_DATA_W-1:0]  coef_bank;
    logic [2:0]               coef_sel;
    logic signed [COEF_W-1:0] k;
    logic signed [ACC_W-1:0]  d;
    logic signed [ACC_W-1:0]  p_rnd;

    assign coef_bank = {i_coeffs_high, i_coeffs_low};
    assign coef_sel  = 3'(i_stage);
    assign k         = coef_bank[coef_sel*COEF_W +: COEF_W];
    assign d         = r_delay[i_stage];
    assign p_rnd     = rnd_prod(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_f <= ACC_W'(i_sample);
            r_g <= ACC_W'(i_sample);
        end
        if (i_ctrl.mul_f) begin
            r_prod <= k * r_f;
        end
        if (i_ctrl.mul_d) begin
            r_prod <= k * d;
        end
        // product in r_prod is k*f here
        if (i_ctrl.g_sub) begin
            r_gn <= add_sat(d, p_rnd, 1'b1);
        end
        if (i_ctrl.f_add) begin
            r_f <= add_sat(r_f, p_rnd, 1'b0);
            r_g <= r_gn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_delay[i] <= '0;
            end
        end else if (i_ctrl.g_sub) begin
            r_delay[i_stage] <= r_g;
        end
    end

    always_comb begin
        if (r_g > $signed(ACC_W'({1'b0, {(SAMPLE_W-1){1'b1}}}))) begin
            o_result = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (r_g < $signed({{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}})) begin
            o_result = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_result = r_g[SAMPLE_W-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: src/lattice_filter_n_stage.sv
`default_nettype none
// FIR lattice filter, up to MAX_STAGES stages, one Q1.23 sample in and one
// saturated Q1.23 sample out per transaction; tlast rides along unchanged.
// Reflection coefficients are Q1.15 (stages 0-3 in register 1, 4-7 in
// register 2, stage 0 / 4 in the low bits); register 0 sets the stages in
// use, clamped to MAX_STAGES, with zero passing the sample straight through.
// Any write to registers 0-2 clears the stage delays, as does reset; write
// only while idle. A sample is taken in the idle step; a small microprogram
// then steps one shared 16x32 multiplier through two products and one update
// step per stage in use, and a last step loads the output register once it
// is free. A new sample is taken once the previous result sits in the output
// register.
module lattice_filter_n_stage
    import lfn_pkg::*;
#(
    parameter int MAX_STAGES = MAX_STAGES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [23:0] sample_in
    input  wire logic                  s_axis_tlast,   // block_end
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [SAMPLE_W-1:0]        m_axis_tdata,   // [23:0] sample_out
    output logic                       m_axis_tlast,   // block_end_out
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int STG_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_STAGES);

    logic [CNT_W-1:0]           r_stage_count;
    logic [CFG_DATA_W-1:0]      r_coeffs_low;
    logic [CFG_DATA_W-1:0]      r_coeffs_high;
    logic                       r_last;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;
    logic                       r_out_last;

    logic                       cfg_wr;
    logic                       cfg_hit;
    logic [CNT_W-1:0]           n_stages;
    logic                       out_free;
    t_ctrl                      ctrl;
    logic [STG_W-1:0]           stage;
    logic signed [SAMPLE_W-1:0] result;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign cfg_hit     = cfg_wr && (i_cfg_index == REG_STAGE_COUNT ||
                                    i_cfg_index == REG_COEFFS_LOW ||
                                    i_cfg_index == REG_COEFFS_HIGH);
    assign n_stages    = (r_stage_count > MAX_N) ? MAX_N : r_stage_count;
    assign out_free    = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_count <= '0;
            r_coeffs_low  <= '0;
            r_coeffs_high <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_STAGE_COUNT: r_stage_count <= i_cfg_data[CNT_W-1:0];
                REG_COEFFS_LOW:  r_coeffs_low  <= i_cfg_data;
                REG_COEFFS_HIGH: r_coeffs_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lfn_sequencer #(
        .MAX_STAGES (MAX_STAGES),
        .STG_W      (STG_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_n_stages (n_stages),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (ctrl),
        .o_stage    (stage)
    );

    lfn_datapath #(
        .MAX_STAGES (MAX_STAGES),
        .STG_W      (STG_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (cfg_hit),
        .i_ctrl        (ctrl),
        .i_stage       (stage),
        .i_sample      ($signed(s_axis_tdata)),
        .i_coeffs_low  (r_coeffs_low),
        .i_coeffs_high (r_coeffs_high),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_last <= s_axis_tlast;
        end
        if (ctrl.emit) begin
            r_out_data <= result;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

FILE: dv/lattice_filter_n_stage_checker.sv
module lattice_filter_n_stage_checker
    import lfn_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [23:0] sample_in
    input  wire logic                  s_axis_tlast,   // block_end
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   m_axis_tdata,   // [23:0] sample_out
    input  wire logic                  m_axis_tlast,   // block_end_out
    input  wire logic                  i_cfg_valid,
    input  wire logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_clipped
);

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_filtered;

    t_filtered                awaited_q[$];
    logic [CNT_W-1:0]         stages_cfg = '0;
    logic [CFG_DATA_W-1:0]    coef_lo    = '0;
    logic [CFG_DATA_W-1:0]    coef_hi    = '0;
    logic signed [ACC_W-1:0]  delay_line [MAX_STAGES_DEF];
    int                       mismatches = 0;
    int                       checked    = 0;
    int                       clipped    = 0;
    int                       waiting    = 0;

    assign o_errors  = mismatches;
    assign o_pending = waiting;
    assign o_checked = checked;
    assign o_clipped = clipped;

    function automatic logic signed [ACC_W-1:0] clip_acc(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[ACC_W-1:0];
    endfunction

    // Q1.15 times Q9.23, +2^14 then floor shift: nearest, ties upward
    function automatic logic signed [ACC_W-1:0] scale_by(input logic signed [COEF_W-1:0] k,
                                                       input logic signed [ACC_W-1:0] v);
        longint p;
        p = longint'(k) * longint'(v) + 64'sd16384;
        return clip_acc(p >>> 15);
    endfunction

    function automatic void clear_delays();
        foreach (delay_line[i]) begin
            delay_line[i] = '0;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] raw);
        logic signed [ACC_W-1:0]  f;
        logic signed [ACC_W-1:0]  g;
        logic signed [ACC_W-1:0]  d;
        logic signed [ACC_W-1:0]  f_next;
        logic signed [ACC_W-1:0]  g_next;
        logic signed [COEF_W-1:0] k;
        int                       n;
        n = (stages_cfg > MAX_STAGES_DEF) ? MAX_STAGES_DEF : int'(stages_cfg);
        f = $signed(raw);
        g = $signed(raw);
        for (int s = 0; s < n; s++) begin
            k = (s < 4) ? coef_lo[s*COEF_W +: COEF_W] : coef_hi[(s-4)*COEF_W +: COEF_W];
            d = delay_line[s];
            f_next = clip_acc(longint'(f) + longint'(scale_by(k, d)));
            g_next = clip_acc(longint'(d) - longint'(scale_by(k, f)));
            delay_line[s] = g;
            f = f_next;
            g = g_next;
        end
        if (g > 32'sd8388607) begin
            clipped++;
            return 24'h7F_FFFF;
        end
        if (g < -32'sd8388608) begin
            clipped++;
            return 24'h80_0000;
        end
        return g[SAMPLE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_filtered want;
        if (!i_rst_n) begin
            stages_cfg = '0;
            coef_lo    = '0;
            coef_hi    = '0;
            clear_delays();
            awaited_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_STAGE_COUNT: begin
                        stages_cfg = i_cfg_data[CNT_W-1:0];
                        clear_delays();
                    end
                    REG_COEFFS_LOW: begin
                        coef_lo = i_cfg_data;
                        clear_delays();
                    end
                    REG_COEFFS_HIGH: begin
                        coef_hi = i_cfg_data;
                        clear_delays();
                    end
                    default: ;
                endcase
            end
            // retire before predicting: a result can never belong to this edge's sample
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_q.size() == 0) begin
                    $display("%0t: unexpected result sample_out %h tlast %b", $time,
                             m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end else begin
                    want = awaited_q.pop_front();
                    checked++;
                    if (m_axis_tdata !== want.sample) begin
                        $display("%0t: sample_out expected %h actual %h", $time,
                                 want.sample, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: block_end_out expected %b actual %b", $time,
                                 want.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want.sample = filter_sample(s_axis_tdata);
                want.last   = s_axis_tlast;
                awaited_q.push_back(want);
            end
        end
        waiting = awaited_q.size();
    end

endmodule

FILE: dv/lattice_filter_n_stage_test.sv
module lattice_filter_n_stage_test;
    import lfn_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 3 * MAX_STAGES_DEF + 6;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 50;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;   // [23:0] sample_in
    logic                  s_axis_tlast  = 1'b0; // block_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;         // [23:0] sample_out
    logic                  m_axis_tlast;         // block_end_out
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int  fail_count;
    int  pending;
    int  checked;
    int  clipped;
    int  settings   = 0;
    bit  tx_calm    = 1'b0;
    bit  rx_calm    = 1'b0;
    bit  hold_req   = 1'b0;

    lattice_filter_n_stage dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    lattice_filter_n_stage_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_clipped    (clipped)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // caller lowers tvalid, so back-to-back transactions keep it high
    task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 29) == 0) begin
            tx_calm = !tx_calm;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [CNT_W-1:0] count, input logic [CFG_DATA_W-1:0] lo,
                             input logic [CFG_DATA_W-1:0] hi);
        logic [CFG_DATA_W-1:0] cnt_word;
        cnt_word = {$urandom(), $urandom()};
        cnt_word[CNT_W-1:0] = count;
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_UNUSED, {$urandom(), $urandom()});
        end
        write_reg(REG_STAGE_COUNT, cnt_word);
        write_reg(REG_COEFFS_LOW, lo);
        write_reg(REG_COEFFS_HIGH, hi);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_coeffs();
        logic [CFG_DATA_W-1:0] word;
        logic [COEF_W-1:0]     k;
        word = '0;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
                0: k = 16'h8000;
                1: k = 16'h7FFF;
                2: k = 16'h0000;
                3: begin
                    k = 16'($urandom_range(0, 4095));
                    if ($urandom_range(0, 1) == 1) begin
                        k = -k;
                    end
                end
                default: k = 16'($urandom());
            endcase
            word[i*COEF_W +: COEF_W] = k;
        end
        return word;
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return {{12{r[31]}}, r[11:0]};
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    // output side: random stalls, quiet stretches, one long hold on request
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 29) == 0) begin
                rx_calm = !rx_calm;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        logic [SAMPLE_W-1:0] corners [8];
        logic [CNT_W-1:0]    count;
        corners = '{24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h80_0000,
                    24'h7F_FFFF, 24'h80_0000, 24'h00_0000, 24'h7F_FFFF};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // straight after reset no stage is in use
        send_sample(24'h7F_FFFF, 1'b1);
        send_sample(24'h80_0000, 1'b0);
        send_sample(24'h00_0000, 1'b1);
        send_sample(24'hFF_FFFF, 1'b0);
        send_sample(24'h00_0001, 1'b1);
        drain_results();

        // over-range stage count, coefficients at both limits, full-scale input
        configure(4'd15, 64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF);
        foreach (corners[i]) begin
            send_sample(corners[i], i[0]);
        end
        drain_results();

        // unused index: delays must survive
        write_reg(REG_UNUSED, '1);
        i_cfg_valid <= 1'b0;
        send_sample(24'h7F_FFFF, 1'b0);
        send_sample(24'h80_0000, 1'b1);
        send_sample(24'h7F_FFFF, 1'b0);
        drain_results();

        configure(4'd8, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
        send_sample(24'h80_0000, 1'b0);
        send_sample(24'h80_0000, 1'b0);
        send_sample(24'h7F_FFFF, 1'b1);
        send_sample(24'h7F_FFFF, 1'b0);
        send_sample(24'h80_0000, 1'b1);
        drain_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: count = 4'd0;
                1: count = 4'd1;
                2: count = 4'd8;
                3: count = 4'd15;
                4: count = 4'd8;
                default: count = 4'($urandom_range(0, 15));
            endcase
            configure(count, pick_coeffs(), pick_coeffs());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == 5) begin
                    hold_req = 1'b1;
                end
                if (ph == 6 && n == 25) begin
                    drain_results();
                end
                send_sample(next_sample(), $urandom_range(0, 7) == 0);
            end
            drain_results();
        end

        $display("Run covered %0d samples over %0d filter settings, stage counts 0 to 15,",
                 checked, settings);
        $display("full-scale coefficients, %0d clipped outputs and a %0d-cycle output stall.",
                 clipped, LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: lattice_filter_n_stage.f
src/lfn_pkg.sv
src/lfn_sequencer.sv
src/lfn_datapath.sv
src/lattice_filter_n_stage.sv
dv/lattice_filter_n_stage_checker.sv
dv/lattice_filter_n_stage_test.sv
